// ===== hw/rtl/apdb_pkg.sv =====
// Package for the analog presence debounce bank.
// Holds widths, reset values, register indexes, phase codes and the item types.
// No dependencies.
`timescale 1ns / 1ps

package apdb_pkg;

   localparam int SENSOR_COUNT_DEF = 6;
   localparam int THRESH_REGS      = 6;
   localparam int INDEX_W          = 3;
   localparam int SAMPLE_W         = 10;
   localparam int TIME_W           = 32;
   localparam int DELAY_W          = 16;
   localparam int MASK_W           = 6;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [SAMPLE_W-1:0] RESET_THRESHOLD = SAMPLE_W'(512);
   localparam logic [DELAY_W-1:0]  RESET_SETTLE    = DELAY_W'(1000);

   // Register indexes 0 to 5 are the per-sensor thresholds.
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD0   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_DELAY = CSR_INDEX_W'(6);

   typedef enum logic [1:0] {
      PH_CLEAR    = 2'd0,
      PH_CAPPING  = 2'd1,
      PH_CAPPED   = 2'd2,
      PH_CLEARING = 2'd3
   } phase_type;

   // Classified sample, passed from the front part to the back part.
   typedef struct packed {
      logic [INDEX_W-1:0] sensor;
      logic               in_range;
      logic               covered;
      logic [TIME_W-1:0]  now_ms;
      logic [TIME_W-1:0]  host_time;
   } front_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] out_sensor;
      phase_type          sensor_state;
      logic               report_valid;
      logic               report_covered;
      logic [TIME_W-1:0]  report_stamp;
      logic [MASK_W-1:0]  covered_mask;
   } result_type;

endpackage

// ===== hw/rtl/apdb_fifo.sv =====
// Small first-in first-out queue of registers.
// Used between the front and back parts and on the result side. No dependencies.
`timescale 1ns / 1ps

module apdb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/apdb_front.sv =====
// Front part: configuration registers and sample classification.
// Compares each sample with its sensor's threshold. Depends on apdb_pkg.
`timescale 1ns / 1ps

module apdb_front #(
   parameter int SENSOR_COUNT = apdb_pkg::SENSOR_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [apdb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [apdb_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [apdb_pkg::INDEX_W-1:0]       sensor_index,
   input  logic [apdb_pkg::SAMPLE_W-1:0]      sample,
   input  logic [apdb_pkg::TIME_W-1:0]        now_ms,
   input  logic [apdb_pkg::TIME_W-1:0]        host_time,
   output apdb_pkg::front_item_type           item,
   output logic [apdb_pkg::DELAY_W-1:0]       settle_delay
);

   localparam int ACTIVE = (SENSOR_COUNT < apdb_pkg::THRESH_REGS) ?
                           SENSOR_COUNT : apdb_pkg::THRESH_REGS;

   logic [apdb_pkg::SAMPLE_W-1:0] thresh_ff [apdb_pkg::THRESH_REGS];
   logic [apdb_pkg::DELAY_W-1:0]  settle_ff;
   logic [apdb_pkg::SAMPLE_W-1:0] thresh_sel;

   assign settle_delay = settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < apdb_pkg::THRESH_REGS; i++) begin
            thresh_ff[i] <= apdb_pkg::RESET_THRESHOLD;
         end
         settle_ff <= apdb_pkg::RESET_SETTLE;
      end else if (csr_valid) begin
         for (int i = 0; i < apdb_pkg::THRESH_REGS; i++) begin
            if (csr_index == apdb_pkg::REG_THRESHOLD0 + apdb_pkg::CSR_INDEX_W'(i)) begin
               thresh_ff[i] <= csr_data[apdb_pkg::SAMPLE_W-1:0];
            end
         end
         if (csr_index == apdb_pkg::REG_SETTLE_DELAY) begin
            settle_ff <= csr_data[apdb_pkg::DELAY_W-1:0];
         end
      end
   end

   always_comb begin
      thresh_sel = '0;
      for (int i = 0; i < apdb_pkg::THRESH_REGS; i++) begin
         if (sensor_index == apdb_pkg::INDEX_W'(i)) begin
            thresh_sel = thresh_ff[i];
         end
      end
      item.sensor    = sensor_index;
      item.in_range  = (sensor_index < apdb_pkg::INDEX_W'(ACTIVE));
      item.covered   = (sample < thresh_sel);
      item.now_ms    = now_ms;
      item.host_time = host_time;
   end

endmodule

// ===== hw/rtl/apdb_back.sv =====
// Back part: per-sensor debounce phases, settle timing and report generation.
// Takes classified samples from the inner queue. Depends on apdb_pkg.
`timescale 1ns / 1ps

module apdb_back #(
   parameter int SENSOR_COUNT = apdb_pkg::SENSOR_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  apdb_pkg::front_item_type      in_item,
   input  logic                          in_empty,
   output logic                          in_pop,
   input  logic [apdb_pkg::DELAY_W-1:0]  settle_delay,
   input  logic                          out_full,
   output logic                          out_push,
   output apdb_pkg::result_type          out_item
);

   localparam int ACTIVE = (SENSOR_COUNT < apdb_pkg::THRESH_REGS) ?
                           SENSOR_COUNT : apdb_pkg::THRESH_REGS;
   localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

   apdb_pkg::phase_type         phase_ff [ACTIVE];
   logic [apdb_pkg::TIME_W-1:0] start_ff [ACTIVE];
   logic [apdb_pkg::MASK_W-1:0] levels_ff, levels_in;

   logic [IDX_W-1:0]            idx;
   apdb_pkg::phase_type         ph_cur, ph_next;
   logic [apdb_pkg::TIME_W-1:0] elapsed;
   logic                        settled, restart, report, fire;

   assign fire     = !in_empty && !out_full;
   assign in_pop   = fire;
   assign out_push = fire;

   always_comb begin
      idx     = in_item.in_range ? in_item.sensor[IDX_W-1:0] : '0;
      ph_cur  = phase_ff[idx];
      elapsed = in_item.now_ms - start_ff[idx];
      settled = elapsed > apdb_pkg::TIME_W'(settle_delay);
      ph_next = ph_cur;
      restart = 1'b0;
      report  = 1'b0;
      // A pending phase that sees the opposite reading flips straight to the
      // other pending phase; only a settled pending phase reports.
      case (ph_cur)
         apdb_pkg::PH_CLEAR: begin
            if (in_item.covered) begin
               ph_next = apdb_pkg::PH_CAPPING;
               restart = 1'b1;
            end
         end
         apdb_pkg::PH_CAPPING: begin
            if (!in_item.covered) begin
               ph_next = apdb_pkg::PH_CLEARING;
               restart = 1'b1;
            end else if (settled) begin
               ph_next = apdb_pkg::PH_CAPPED;
               restart = 1'b1;
               report  = 1'b1;
            end
         end
         apdb_pkg::PH_CAPPED: begin
            if (!in_item.covered) begin
               ph_next = apdb_pkg::PH_CLEARING;
               restart = 1'b1;
            end
         end
         apdb_pkg::PH_CLEARING: begin
            if (in_item.covered) begin
               ph_next = apdb_pkg::PH_CAPPING;
               restart = 1'b1;
            end else if (settled) begin
               ph_next = apdb_pkg::PH_CLEAR;
               restart = 1'b1;
               report  = 1'b1;
            end
         end
         default: begin
            ph_next = apdb_pkg::PH_CLEAR;
         end
      endcase
      if (!in_item.in_range) begin
         ph_next = apdb_pkg::PH_CLEAR;
         restart = 1'b0;
         report  = 1'b0;
      end

      levels_in = levels_ff;
      if (report) begin
         levels_in[in_item.sensor] = in_item.covered;
      end

      out_item.out_sensor     = in_item.sensor;
      out_item.sensor_state   = ph_next;
      out_item.report_valid   = report;
      out_item.report_covered = report && in_item.covered;
      out_item.report_stamp   = report ? in_item.host_time : '0;
      out_item.covered_mask   = levels_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ACTIVE; i++) begin
            phase_ff[i] <= apdb_pkg::PH_CLEAR;
            start_ff[i] <= '0;
         end
         levels_ff <= '0;
      end else if (fire && in_item.in_range) begin
         phase_ff[idx] <= ph_next;
         if (restart) begin
            start_ff[idx] <= in_item.now_ms;
         end
         levels_ff <= levels_in;
      end
   end

endmodule

// ===== hw/rtl/analog_presence_debounce_bank_top.sv =====
// Top level of the analog presence debounce bank.
// Instantiates apdb_front, two apdb_fifo queues and apdb_back; uses apdb_pkg.
//
//   channel   ports                     transfer when
//   --------  ------------------------  -----------------------------
//   request   req_push / req_full       req_push && !req_full
//   response  rsp_pop / rsp_empty       rsp_pop && !rsp_empty
//   csr       csr_valid / csr_ready     csr_valid && csr_ready (ready is 1)
//
// One sample per cycle is sustained while the response side does not stall. A sample's response
// is registered in the inner queue and then in the result queue before it reaches the rsp_ ports.
// The back part reads and updates a sensor's phase and start time in the
// same cycle, so consecutive samples of one sensor need no bypass.
// Reset is synchronous; both queues come out empty.
// A stalled response side fills the result queue, then the inner queue, then raises req_full.
`timescale 1ns / 1ps

module analog_presence_debounce_bank_top #(
   parameter int SENSOR_COUNT = apdb_pkg::SENSOR_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [apdb_pkg::INDEX_W-1:0]      req_sensor_index,
   input  logic [apdb_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic [apdb_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [apdb_pkg::TIME_W-1:0]       req_host_time,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [apdb_pkg::INDEX_W-1:0]      rsp_out_sensor,
   output logic [1:0]                        rsp_sensor_state,
   output logic                              rsp_report_valid,
   output logic                              rsp_report_covered,
   output logic [apdb_pkg::TIME_W-1:0]       rsp_report_stamp,
   output logic [apdb_pkg::MASK_W-1:0]       rsp_covered_mask,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [apdb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [apdb_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int ITEM_W   = $bits(apdb_pkg::front_item_type);
   localparam int RESULT_W = $bits(apdb_pkg::result_type);

   apdb_pkg::front_item_type      front_item, back_item;
   apdb_pkg::result_type          back_result, head_result;
   logic [apdb_pkg::DELAY_W-1:0]  settle_delay;
   logic                          mid_empty, mid_pop;
   logic                          out_full, out_push;
   logic [ITEM_W-1:0]             mid_head;
   logic [RESULT_W-1:0]           out_head;

   assign csr_ready = 1'b1;

   apdb_front #(
      .SENSOR_COUNT(SENSOR_COUNT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .sensor_index (req_sensor_index),
      .sample       (req_sample),
      .now_ms       (req_now_ms),
      .host_time    (req_host_time),
      .item         (front_item),
      .settle_delay (settle_delay)
   );

   apdb_fifo #(
      .WIDTH(ITEM_W),
      .DEPTH(apdb_pkg::QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (mid_head),
      .empty     (mid_empty)
   );

   assign back_item = apdb_pkg::front_item_type'(mid_head);

   apdb_back #(
      .SENSOR_COUNT(SENSOR_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_item      (back_item),
      .in_empty     (mid_empty),
      .in_pop       (mid_pop),
      .settle_delay (settle_delay),
      .out_full     (out_full),
      .out_push     (out_push),
      .out_item     (back_result)
   );

   apdb_fifo #(
      .WIDTH(RESULT_W),
      .DEPTH(apdb_pkg::QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_head),
      .empty     (rsp_empty)
   );

   assign head_result        = apdb_pkg::result_type'(out_head);
   assign rsp_out_sensor     = head_result.out_sensor;
   assign rsp_sensor_state   = head_result.sensor_state;
   assign rsp_report_valid   = head_result.report_valid;
   assign rsp_report_covered = head_result.report_covered;
   assign rsp_report_stamp   = head_result.report_stamp;
   assign rsp_covered_mask   = head_result.covered_mask;

endmodule

// ===== hw/rtl/apdb_checker.sv =====
// Port-level checks for the analog presence debounce bank, bound to the top level.
// Sees only the top-level ports. Depends on apdb_pkg.
`timescale 1ns / 1ps

module apdb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_push,
   input logic                              req_full,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input logic [apdb_pkg::INDEX_W-1:0]      rsp_out_sensor,
   input logic [1:0]                        rsp_sensor_state,
   input logic                              rsp_report_valid,
   input logic                              rsp_report_covered,
   input logic [apdb_pkg::TIME_W-1:0]       rsp_report_stamp
);

   // Without a report, the level and stamp fields read as zero.
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_report_valid |-> !rsp_report_covered && rsp_report_stamp == '0)
      else $error("report fields set without a report");

   // A report always lands the sensor in the settled phase for its level.
   a_report_phase: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_report_valid |->
         (rsp_report_covered && rsp_sensor_state == apdb_pkg::PH_CAPPED) ||
         (!rsp_report_covered && rsp_sensor_state == apdb_pkg::PH_CLEAR))
      else $error("report with a phase that does not match its level");

   // Samples for sensors beyond the bank never change anything.
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_out_sensor >= apdb_pkg::INDEX_W'(apdb_pkg::THRESH_REGS) |->
         !rsp_report_valid && rsp_sensor_state == apdb_pkg::PH_CLEAR)
      else $error("out-of-range sensor produced state or a report");

   // A waiting response that is not taken stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_sensor) &&
         $stable(rsp_report_stamp))
      else $error("waiting response changed before its transfer");

   // Reset leaves both queues empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule

bind analog_presence_debounce_bank_top apdb_checker u_apdb_checker (.*);
